[src/bdll_pkg.sv]
`default_nettype none

package bdll_pkg;

    // sizes
    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_KEY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ITEM = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] element_key;
        logic                    last;
    } t_out_item;

    // what one cell holds and shows its neighbors
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
    } t_link;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INSERT,
        CO_DEL_KEY,
        CO_DEL_FIRST,
        CO_DEL_LAST,
        CO_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

`default_nettype wire

[src/bdll_cell.sv]
`default_nettype none

module bdll_cell
    import bdll_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cell_op                i_op,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire logic signed [KEY_W-1:0] i_front_key,
    input  wire t_link                   i_prev,
    input  wire t_link                   i_next,
    input  wire logic                    i_found,
    output t_link                        o_link,
    output logic                         o_found
);

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic                    n_valid;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_match;
    logic                    w_tail;

    // key match and first-match chain toward the back
    assign w_match = r_valid && (r_key == i_key);
    assign o_found = i_found || w_match;
    assign w_tail  = r_valid && !i_next.valid;

    assign o_link.valid = r_valid;
    assign o_link.key   = r_key;

    // next contents of the cell
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        case (i_op)
            CO_INSERT: begin
                n_valid = r_valid || i_prev.valid;
                n_key   = i_prev.key;
            end
            CO_DEL_KEY: begin
                if (o_found) begin
                    n_valid = i_next.valid;
                    n_key   = i_next.key;
                end
            end
            CO_DEL_FIRST: begin
                n_valid = i_next.valid;
                n_key   = i_next.key;
            end
            CO_DEL_LAST: begin
                if (w_tail) begin
                    n_valid = 1'b0;
                end
            end
            CO_ROTATE: begin
                if (w_tail) begin
                    n_key = i_front_key;
                end else if (r_valid) begin
                    n_key = i_next.key;
                end
            end
            default: begin
                n_valid = r_valid;
                n_key   = r_key;
            end
        endcase
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

[src/bounded_doubly_linked_list_unit.sv]
// Ordered list of up to CAPACITY signed keys held in a row of cells, front in cell 0.
// Input channel: i_in_valid / o_in_stall carry i_in_item (command, key).
// Output channel: o_out_valid / i_out_stall carry o_out_item (status, element_key, last).
// A transfer happens at a clock edge where valid is high and stall is low.
// Insert, delete by key, delete first, delete last and unknown commands give a
// single result: the cells shift at the edge of the input transfer, and that same
// edge loads the result into the output register.
// A dump of n elements enters a listing phase: while the output register is free,
// the row rotates by one cell per cycle and each rotation emits the front key,
// giving n results; the input is stalled until the last one is loaded.
// A dump of an empty list gives one result with status nothing-found.
// Throughput is one command per cycle, set by the single output register, while
// the receiver does not stall; the next command after a dump waits for its last result.
// When the receiver stalls, the output register holds and no new command or
// listed element is taken until it empties.
// Synchronous reset empties the list and drops any pending result; no clearing
// pass is needed.
`default_nettype none

module bounded_doubly_linked_list_unit
    import bdll_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             w_load;
    t_cell_op         w_op;
    logic             w_slot_free;
    logic             w_in_xfer;
    logic             w_full;
    logic             w_empty;
    logic             w_found;
    logic             w_dump_last;

    t_link            w_link  [CAPACITY];
    logic             w_chain [CAPACITY+1];

    // row of cells
    assign w_chain[0] = 1'b0;
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_link w_prev;
        t_link w_next;
        if (i == 0) begin : g_head
            assign w_prev.valid = 1'b1;
            assign w_prev.key   = i_in_item.key;
        end else begin : g_body
            assign w_prev = w_link[i-1];
        end
        if (i == CAPACITY - 1) begin : g_end
            assign w_next.valid = 1'b0;
            assign w_next.key   = '0;
        end else begin : g_mid
            assign w_next = w_link[i+1];
        end
        bdll_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op),
            .i_key       (i_in_item.key),
            .i_front_key (w_link[0].key),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .i_found     (w_chain[i]),
            .o_link      (w_link[i]),
            .o_found     (w_chain[i+1])
        );
    end

    // handshake and list status
    assign w_found     = w_chain[CAPACITY];
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_dump_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !w_slot_free;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (i_in_item.command == CMD_DUMP) && !w_empty) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (w_slot_free && w_dump_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // cell operation and result
    always_comb begin
        w_op   = CO_HOLD;
        w_load = 1'b0;
        n_out  = '0;
        n_out.last = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    w_load       = 1'b1;
                    n_out.status = STAT_DONE;
                    case (i_in_item.command)
                        CMD_INSERT: begin
                            if (w_full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                w_op = CO_INSERT;
                            end
                        end
                        CMD_DEL_KEY: begin
                            w_op = CO_DEL_KEY;
                            if (!w_found) begin
                                n_out.status = STAT_NONE;
                            end
                        end
                        CMD_DEL_FIRST: begin
                            if (w_empty) begin
                                n_out.status = STAT_NONE;
                            end else begin
                                w_op = CO_DEL_FIRST;
                            end
                        end
                        CMD_DEL_LAST: begin
                            if (w_empty) begin
                                n_out.status = STAT_NONE;
                            end else begin
                                w_op = CO_DEL_LAST;
                            end
                        end
                        CMD_DUMP: begin
                            if (w_empty) begin
                                n_out.status = STAT_NONE;
                            end else begin
                                w_load = 1'b0;
                            end
                        end
                        default: n_out.status = STAT_DONE;
                    endcase
                end
            end
            ST_DUMP: begin
                if (w_slot_free) begin
                    w_op              = CO_ROTATE;
                    w_load            = 1'b1;
                    n_out.status      = STAT_ITEM;
                    n_out.element_key = w_link[0].key;
                    n_out.last        = w_dump_last;
                end
            end
            default: w_op = CO_HOLD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_op == CO_INSERT) begin
                r_count <= r_count + CNT_W'(1);
            end else if ((w_op == CO_DEL_FIRST) || (w_op == CO_DEL_LAST) ||
                         ((w_op == CO_DEL_KEY) && w_found)) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (r_state == ST_IDLE) begin
                r_idx <= '0;
            end else if (w_op == CO_ROTATE) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[src/bdll_checker.sv]
`default_nettype none

module bdll_assertions
    import bdll_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // reset drops any pending result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a command other than dump gives its result in the next cycle
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.command != CMD_DUMP)
        |=> o_out_valid && o_out_item.last)
        else $error("single result missing");

    // mid-listing the input stays stalled; only listed elements can be non-final
    a_listing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> o_in_stall && (o_out_item.status == STAT_ITEM))
        else $error("non-final result outside a listing");

endmodule

bind bounded_doubly_linked_list_unit bdll_assertions u_bdll_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

[sim/bdll_checker.sv]
`timescale 1ns / 100ps

module bdll_checker
    import bdll_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_pending
);

    // keep the log short when things go badly wrong
    localparam int REPORT_LIMIT = 40;

    // shadow list, front at index 0, and the results still owed by the block
    logic signed [KEY_W-1:0] list_keys[$];
    t_out_item               owed_results[$];
    int                      fail_count = 0;
    int                      owed_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = owed_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < REPORT_LIMIT)
            $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic t_out_item make_result(input logic [STATUS_W-1:0] status,
                                              input logic signed [KEY_W-1:0] element_key,
                                              input logic last);
        t_out_item res;
        res.status      = status;
        res.element_key = element_key;
        res.last        = last;
        return res;
    endfunction

    // run one command against the shadow list and queue what it should emit
    task automatic apply_command(input t_in_item item);
        int idx;
        bit found;
        found = 1'b0;
        case (item.command)
            CMD_INSERT: begin
                if (list_keys.size() >= CAPACITY) begin
                    owed_results.push_back(make_result(STAT_FULL, '0, 1'b1));
                end else begin
                    list_keys.push_front(item.key);
                    owed_results.push_back(make_result(STAT_DONE, '0, 1'b1));
                end
            end
            CMD_DEL_KEY: begin
                // only the first match from the front goes
                for (idx = 0; idx < list_keys.size() && !found; idx++) begin
                    if (list_keys[idx] == item.key) begin
                        list_keys.delete(idx);
                        found = 1'b1;
                    end
                end
                owed_results.push_back(make_result(found ? STAT_DONE : STAT_NONE, '0, 1'b1));
            end
            CMD_DEL_FIRST, CMD_DEL_LAST: begin
                if (list_keys.size() == 0) begin
                    owed_results.push_back(make_result(STAT_NONE, '0, 1'b1));
                end else begin
                    if (item.command == CMD_DEL_FIRST)
                        void'(list_keys.pop_front());
                    else
                        void'(list_keys.pop_back());
                    owed_results.push_back(make_result(STAT_DONE, '0, 1'b1));
                end
            end
            CMD_DUMP: begin
                if (list_keys.size() == 0) begin
                    owed_results.push_back(make_result(STAT_NONE, '0, 1'b1));
                end else begin
                    for (idx = 0; idx < list_keys.size(); idx++)
                        owed_results.push_back(make_result(STAT_ITEM, list_keys[idx],
                                                           idx == list_keys.size() - 1));
                end
            end
            // unknown commands are ignored but still answered
            default: owed_results.push_back(make_result(STAT_DONE, '0, 1'b1));
        endcase
    endtask

    // compare the result transfer first: it always belongs to an older command
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            list_keys.delete();
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected result status", i_out_item.status, -1);
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_item.status !== want.status)
                        report_mismatch("status", i_out_item.status, want.status);
                    if (i_out_item.element_key !== want.element_key)
                        report_mismatch("element_key", i_out_item.element_key,
                                        want.element_key);
                    if (i_out_item.last !== want.last)
                        report_mismatch("last", i_out_item.last, want.last);
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_command(i_in_item);
        end
        owed_count = owed_results.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
    import bdll_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int POOL_SIZE  = 8;
    // commands past dump are undefined and must be ignored
    localparam logic [CMD_W-1:0] CMD_BAD_FIRST = CMD_DUMP + CMD_W'(1);

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int fail_count;
    int pending;
    int idle_cycles   = 0;
    int burst_left    = 0;
    int max_gap       = 4;
    bit long_hold_req = 1'b0;

    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

    bounded_doubly_linked_list_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    bdll_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: too long without any transfer means the block is stuck
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: segments of random stall density, plus one long hold on request
    initial begin
        int seg_len;
        int stall_pct;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                seg_len   = $urandom_range(4, 40);
                stall_pct = 25 * $urandom_range(0, 3);
                repeat (seg_len) begin
                    @(negedge i_clk);
                    i_out_stall <= ($urandom_range(0, 99) < stall_pct);
                end
            end
        end
    end

    // offer one command and hold it until the transfer; returns on a falling edge
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key);
        t_in_item item;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        item.command = cmd;
        item.key     = key;
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // stop sending until every owed result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // keys half the time from a small pool so deletes by key find matches
    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 1) == 0)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int ins_pct, input int dump_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return CMD_INSERT;
        if (r < ins_pct + dump_pct)
            return CMD_DUMP;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CMD_DEL_KEY;
            4, 5:       return CMD_DEL_FIRST;
            6, 7:       return CMD_DEL_LAST;
            default:    return CMD_BAD_FIRST + CMD_W'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic run_phase(input int count, input int ins_pct, input int dump_pct,
                             input int gap_limit);
        max_gap = gap_limit;
        repeat (count) send_item(pick_command(ins_pct, dump_pct), pick_key());
    endtask

    initial begin
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extreme keys, misses, duplicates, unknown commands
        send_item(CMD_DUMP, 0);
        send_item(CMD_DEL_KEY, 0);
        send_item(CMD_DEL_FIRST, 0);
        send_item(CMD_DEL_LAST, 0);
        send_item(CMD_INSERT, 32'sh8000_0000);
        send_item(CMD_INSERT, 32'sh7fff_ffff);
        send_item(CMD_INSERT, 0);
        send_item(CMD_INSERT, -1);
        send_item(CMD_INSERT, 1);
        send_item(CMD_DUMP, 0);
        send_item(CMD_DEL_KEY, 12345);
        send_item(CMD_DEL_KEY, 32'sh7fff_ffff);
        send_item(CMD_DEL_FIRST, -1);
        send_item(CMD_DEL_LAST, 0);
        send_item(CMD_DUMP, 0);
        send_item(CMD_BAD_FIRST, -1);
        send_item(CMD_BAD_FIRST + CMD_W'(1), 0);
        send_item(CMD_BAD_FIRST + CMD_W'(2), 32'sh7fff_ffff);
        send_item(CMD_INSERT, 32'sh7fff_ffff);
        send_item(CMD_INSERT, 32'sh7fff_ffff);
        send_item(CMD_DEL_KEY, 32'sh7fff_ffff);
        send_item(CMD_DUMP, 0);
        wait_drained();

        // random traffic: mixed, fill past capacity, long receiver hold, drain, refill
        run_phase(30, 50, 10, 4);
        run_phase(45, 85, 5, 2);
        long_hold_req = 1'b1;
        // start sending only once the receiver has begun its hold
        wait (!long_hold_req);
        run_phase(25, 60, 10, 0);
        wait_drained();
        run_phase(45, 15, 10, 6);
        run_phase(40, 90, 3, 0);
        wait_drained();
        run_phase(40, 40, 15, 3);

        // let any stray result show up before the verdict
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[bounded_doubly_linked_list_unit.f]
src/bdll_pkg.sv
src/bdll_cell.sv
src/bounded_doubly_linked_list_unit.sv
src/bdll_checker.sv
sim/bdll_checker.sv
sim/tb.sv
